@@ hw/rtl/wave_string_stencil_step_assert.svh @@
// assertion macros for the top-level rtl module
`ifndef WAVE_STRING_STENCIL_STEP_ASSERT_SVH
`define WAVE_STRING_STENCIL_STEP_ASSERT_SVH

// a condition implies a consequence on the next cycle
`define WSS_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

// a condition implies a consequence on the same cycle
`define WSS_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/wss_pkg.sv @@
`default_nettype none
package wss_pkg;
   localparam int DefaultCells = 256;
   localparam int DataW = 32;
   localparam int IdxW = 8;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_STEP  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_MODE = 3'd0,
      REG_STEP = 3'd1,
      REG_LAPG = 3'd2,
      REG_LIN  = 3'd3,
      REG_CUB  = 3'd4,
      REG_GRAD = 3'd5
   } reg_type;

   typedef enum logic [1:0] {
      MODE_MEDIUM = 2'd0,
      MODE_KG     = 2'd1,
      MODE_GRAD   = 2'd2,
      MODE_FREE   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_STEP = 2'd1,
      ST_CALC = 2'd2,
      ST_RESP = 2'd3
   } state_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [30:0] step_size;
      logic [30:0] lap_gain;
      logic signed [31:0] lin;
      logic signed [31:0] cub;
      logic signed [31:0] grad;
   } cfg_type;

   // one cell's state as it travels along the row
   typedef struct packed {
      logic signed [31:0] dc;
      logic signed [31:0] dp;
      logic signed [31:0] vc;
      logic signed [31:0] vp;
      logic signed [31:0] med;
   } cell_type;

   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      logic signed [31:0] r;
      if (v > 72'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -72'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic oflow(input logic signed [71:0] v);
      return (v > 72'sh0_7FFF_FFFF) || (v < -72'sh0_8000_0000);
   endfunction
endpackage
`default_nettype wire

@@ hw/rtl/wss_if.sv @@
`default_nettype none
interface wss_req_if;
   logic valid;
   logic ready;
   logic [1:0] cmd;
   logic [7:0] cell_index;
   logic signed [31:0] displacement_in;
   logic signed [31:0] velocity_in;
   logic signed [31:0] medium_in;
   modport source (output valid, cmd, cell_index, displacement_in, velocity_in,
      medium_in, input ready);
   modport sink (input valid, cmd, cell_index, displacement_in, velocity_in,
      medium_in, output ready);
endinterface

interface wss_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] displacement_out;
   logic signed [31:0] velocity_out;
   logic signed [31:0] medium_out;
   logic saturated;
   modport source (output valid, displacement_out, velocity_out, medium_out,
      saturated, input ready);
   modport sink (input valid, displacement_out, velocity_out, medium_out,
      saturated, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/wss_cell.sv @@
`default_nettype none
// one storage cell of the row: holds a cell state, shifts it on when told
module wss_cell import wss_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     shift,
   input  wire logic     wr,
   input  wire cell_type wr_data,
   input  wire cell_type from_prev,
   output cell_type      q
);
   cell_type q_ff, q_in;
   always_comb begin
      q_in = q_ff;
      if (shift) q_in = from_prev;
      else if (wr) q_in = wr_data;
   end
   always_ff @(posedge clock) begin
      if (reset) q_ff <= '0;
      else q_ff <= q_in;
   end
   assign q = q_ff;
endmodule
`default_nettype wire

@@ hw/rtl/wss_calc.sv @@
`default_nettype none
// stencil arithmetic: three registered stages
module wss_calc import wss_pkg::*; (
   input  wire logic     clock,
   input  wire logic     start,
   input  wire cfg_type  cfg,
   input  wire cell_type left,
   input  wire cell_type mid,
   input  wire logic signed [31:0] right_dc,
   output logic signed [31:0] nd,
   output logic signed [31:0] nv,
   output logic          sat,
   output logic          done
);
   // stage 1
   logic signed [71:0] g_ff, g_in, sq_ff, sq_in, nd_ff, nd_in;
   logic signed [31:0] u_ff, med_ff, vp_ff;
   logic s1_sat_ff, s1_sat_in;
   logic [2:0] v_ff;
   logic signed [71:0] l, dfull, p_lin, p_cub;
   logic signed [31:0] dsat, sq1, sq2, c;
   // stage 2
   logic signed [71:0] t2_ff, t2_in;
   logic signed [31:0] c_ff, c_in;
   logic s2_sat_ff, s2_sat_in;
   // stage 3
   logic signed [71:0] term_ff, term_in;
   logic s3_sat_ff, s3_sat_in;

   function automatic logic signed [71:0] fl16(input logic signed [71:0] p);
      return p >>> 16;
   endfunction

   always_comb begin
      l = 72'(left.dc) - (72'(mid.dc) <<< 1) + 72'(right_dc);
      g_in = (l * $signed({57'd0, cfg.lap_gain[30:16]}))
             + fl16(l * $signed({56'd0, cfg.lap_gain[15:0]}));
      sq_in = fl16(72'(mid.dc) * 72'(mid.dc));
      dfull = 72'(right_dc) - 72'(left.dc);
      nd_in = 72'(mid.dp) + fl16($signed({41'd0, cfg.step_size}) * 72'(mid.vc));
      s1_sat_in = 1'b0;
      if (cfg.mode == MODE_GRAD) begin
         dsat = sat32(dfull);
         s1_sat_in = oflow(dfull);
         sq_in = fl16(72'(dsat) * 72'(dsat));
      end else begin
         dsat = '0;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= {v_ff[1:0], start};
      g_ff <= g_in; sq_ff <= sq_in; nd_ff <= nd_in; s1_sat_ff <= s1_sat_in;
      u_ff <= mid.dc; med_ff <= mid.med; vp_ff <= mid.vp;
      t2_ff <= t2_in; c_ff <= c_in; s2_sat_ff <= s2_sat_in;
      term_ff <= term_in; s3_sat_ff <= s3_sat_in;
   end

   // stage 2: medium product, cube, or gradient product
   always_comb begin
      sq1 = sat32(sq_ff);
      sq2 = '0;
      c_in = '0;
      t2_in = g_ff;
      s2_sat_in = s1_sat_ff;
      case (mode_type'(cfg.mode))
         MODE_MEDIUM: begin
            t2_in = fl16(72'(med_ff) * 72'(sat32(g_ff)));
            s2_sat_in = s1_sat_ff | oflow(g_ff);
         end
         MODE_KG: begin
            s2_sat_in = s1_sat_ff | oflow(sq_ff);
            c_in = '0;
            t2_in = g_ff - fl16(72'(cfg.lin) * 72'(u_ff));
            sq2 = sat32(fl16(72'(sq1) * 72'(u_ff)));
            s2_sat_in = s2_sat_in | oflow(fl16(72'(sq1) * 72'(u_ff)));
            c_in = sq2;
         end
         MODE_GRAD: begin
            s2_sat_in = s1_sat_ff | oflow(sq_ff);
            t2_in = g_ff + fl16(72'(cfg.grad) * 72'(sq1));
         end
         default: t2_in = g_ff;
      endcase
   end

   // stage 3: cubic restoring product
   always_comb begin
      c = c_ff;
      p_cub = fl16(72'(cfg.cub) * 72'(c));
      p_lin = '0;
      term_in = t2_ff;
      if (cfg.mode == MODE_KG) term_in = t2_ff - p_cub - p_lin;
      s3_sat_in = s2_sat_ff;
   end

   // nd path delayed to line up with the term
   logic signed [71:0] nd2_ff, nd3_ff;
   logic signed [31:0] vp2_ff, vp3_ff;
   always_ff @(posedge clock) begin
      nd2_ff <= nd_ff; nd3_ff <= nd2_ff;
      vp2_ff <= vp_ff; vp3_ff <= vp2_ff;
   end

   logic signed [71:0] nv_full;
   assign nv_full = 72'(vp3_ff) + term_ff;
   assign nd = sat32(nd3_ff);
   assign nv = sat32(nv_full);
   assign sat = s3_sat_ff | oflow(nd3_ff) | oflow(nv_full);
   assign done = v_ff[2];
endmodule
`default_nettype wire

@@ hw/rtl/wave_string_stencil_step.sv @@
`default_nettype none
// Wave string stencil engine. One command per transfer, one response each.
// A write or read answers in the cycle after its transfer, and the next command
// is taken once that response has gone. A time step rotates the whole row of
// CELLS cells once through the stencil unit, one cell per shift: a boundary cell
// shifts at once, each interior cell is launched into the three-stage arithmetic
// and shifts when its result comes back, and the response follows the last
// shift. Storage is the cell row itself; a read or write walks no memory, it
// picks its cell by index from the row.
`include "wave_string_stencil_step_assert.svh"
module wave_string_stencil_step import wss_pkg::*; #(
   parameter int CELLS = DefaultCells
) (
   input  wire logic  clock,
   input  wire logic  reset,
   wss_req_if.sink    req,
   wss_rsp_if.source  rsp,
   input  wire logic  csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [31:0] csr_wdata
);
   localparam int CW = $clog2(CELLS + 1);
   localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

   cfg_type cfg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: 2'd0, step_size: 31'd65536, lap_gain: 31'd16384,
                     lin: '0, cub: '0, grad: '0};
      end else if (csr_we) begin
         case (reg_type'(csr_index))
            REG_MODE: cfg_ff.mode <= csr_wdata[1:0];
            REG_STEP: cfg_ff.step_size <= csr_wdata[30:0];
            REG_LAPG: cfg_ff.lap_gain <= csr_wdata[30:0];
            REG_LIN:  cfg_ff.lin <= csr_wdata;
            REG_CUB:  cfg_ff.cub <= csr_wdata;
            REG_GRAD: cfg_ff.grad <= csr_wdata;
            default: ;
         endcase
      end
   end

   // row: index 0 is head, shift moves content from i+1 to i with wrap
   cell_type q [CELLS];
   cell_type head_new;
   logic shift, wr_en;
   logic [AW-1:0] wr_idx;
   logic [AW-1:0] sel_idx;
   cell_type wr_data;

   assign sel_idx = AW'(req.cell_index);

   // previous leaving cell, as it was before its update (interior or boundary)
   cell_type left_ff, left_in; // original state of cell i-1
   logic signed [31:0] nd_last_ff;

   for (genvar i = 0; i < CELLS; i++) begin : g_row
      cell_type nb;
      if (i == CELLS - 1) begin : g_tail
         assign nb = head_new;
      end else begin : g_mid
         assign nb = q[i + 1];
      end
      wss_cell u_cell (
         .clock(clock), .reset(reset), .shift(shift),
         .wr(wr_en && (wr_idx == AW'(i))), .wr_data(wr_data),
         .from_prev(nb), .q(q[i])
      );
   end

   state_type st_ff, st_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic sat_ff, sat_in;
   logic rv_ff, rv_in;
   logic signed [31:0] rd_ff, rd_in, rv2_ff, rv2_in, rm_ff, rm_in;
   logic rs_ff, rs_in;

   logic calc_start, calc_done, calc_sat;
   logic signed [31:0] nd, nv;
   wss_calc u_calc (
      .clock(clock), .start(calc_start), .cfg(cfg_ff), .left(left_ff), .mid(q[0]),
      .right_dc(q[1].dc), .nd(nd), .nv(nv), .sat(calc_sat), .done(calc_done)
   );

   logic accept;
   assign accept = req.valid && req.ready;
   assign req.ready = (st_ff == ST_IDLE) && !rv_ff;

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (accept && cmd_type'(req.cmd) == CMD_STEP) st_in = ST_STEP;
         ST_STEP: begin
            if (pos_ff == CW'(CELLS)) st_in = ST_IDLE;
            else if (pos_ff != '0 && pos_ff != CW'(CELLS - 1)) st_in = ST_CALC;
         end
         ST_CALC: if (calc_done) st_in = ST_STEP;
         default: st_in = ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      shift = 1'b0;
      calc_start = 1'b0;
      head_new = q[0];
      pos_in = pos_ff;
      sat_in = sat_ff;
      left_in = left_ff;
      rv_in = rv_ff && !rsp.ready;
      rd_in = rd_ff; rv2_in = rv2_ff; rm_in = rm_ff; rs_in = rs_ff;
      wr_en = 1'b0;
      wr_idx = sel_idx;
      wr_data = '{dc: req.displacement_in, dp: req.displacement_in,
                  vc: req.velocity_in, vp: req.velocity_in, med: req.medium_in};
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               rv_in = 1'b1;
               rd_in = '0; rv2_in = '0; rm_in = '0; rs_in = 1'b0;
               pos_in = '0;
               sat_in = 1'b0;
               if (cmd_type'(req.cmd) == CMD_WRITE)
                  wr_en = 32'(req.cell_index) < CELLS;
               else if (cmd_type'(req.cmd) == CMD_STEP)
                  rv_in = 1'b0;
               else if (cmd_type'(req.cmd) == CMD_READ && 32'(req.cell_index) < CELLS) begin
                  rd_in = q[sel_idx].dc;
                  rv2_in = q[sel_idx].vc;
                  rm_in = q[sel_idx].med;
               end
            end
         end
         ST_STEP: begin
            if (pos_ff == CW'(CELLS)) begin
               rv_in = 1'b1; rs_in = sat_ff;
               rd_in = '0; rv2_in = '0; rm_in = '0;
            end else if (pos_ff == '0 || pos_ff == CW'(CELLS - 1)) begin
               // boundary: levels rotate, current kept (a free-mode tail takes the last interior displacement)
               shift = 1'b1;
               head_new = '{dc: q[0].dc, dp: q[0].dc, vc: q[0].vc, vp: q[0].vc,
                            med: q[0].med};
               if (pos_ff == CW'(CELLS - 1) && cfg_ff.mode == MODE_FREE)
                  head_new.dc = nd_last_ff;
               left_in = q[0];
               pos_in = pos_ff + CW'(1);
            end else begin
               calc_start = 1'b1;
            end
         end
         ST_CALC: begin
            if (calc_done) begin
               shift = 1'b1;
               head_new = '{dc: nd, dp: q[0].dc, vc: nv, vp: q[0].vc, med: q[0].med};
               sat_in = sat_ff | calc_sat;
               left_in = q[0];
               pos_in = pos_ff + CW'(1);
            end
         end
         default: ;
      endcase
   end

   // new displacement of the last interior cell; in free mode the tail boundary
   // cell takes it as its current displacement
   logic signed [31:0] nd_last_in;
   assign nd_last_in = (st_ff == ST_CALC && calc_done) ? nd : nd_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; pos_ff <= '0; sat_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; pos_ff <= pos_in; sat_ff <= sat_in; rv_ff <= rv_in;
      end
      left_ff <= left_in; nd_last_ff <= nd_last_in;
      rd_ff <= rd_in; rv2_ff <= rv2_in; rm_ff <= rm_in; rs_ff <= rs_in;
   end

   assign rsp.valid = rv_ff;
   assign rsp.displacement_out = rd_ff;
   assign rsp.velocity_out = rv2_ff;
   assign rsp.medium_out = rm_ff;
   assign rsp.saturated = rs_ff;

   `WSS_ASSERT_NOW(a_no_accept_busy, clock, reset, st_ff != ST_IDLE, !req.ready,
      "input taken during a step")
   `WSS_ASSERT_NEXT(a_step_ends_resp, clock, reset,
      st_ff == ST_STEP && pos_ff == CW'(CELLS), rv_ff, "step gave no response")
   `WSS_ASSERT_NOW(a_shift_no_write, clock, reset, shift, !wr_en,
      "write during row rotation")
   `WSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(rsp.displacement_out), "response dropped")
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

import wss_pkg::*;

typedef struct {
   logic signed [31:0] disp;
   logic signed [31:0] vel;
   logic signed [31:0] med;
   logic               sat;
} cell_reply_type;

class wave_scoreboard;
   logic signed [31:0] disp_now[256], disp_old[256], vel_now[256], vel_old[256], coeff[256];
   logic [1:0] mode;
   longint step_size, lap_gain, lin_gain, cub_gain, grad_gain;
   cell_reply_type replies_due[$];
   int errors, checked, steps_done, sat_steps;

   function void clear();
      foreach (disp_now[i]) begin
         disp_now[i] = 0; disp_old[i] = 0; vel_now[i] = 0; vel_old[i] = 0; coeff[i] = 0;
      end
      mode = MODE_MEDIUM;
      step_size = 65536;
      lap_gain = 16384;
      lin_gain = 0;
      cub_gain = 0;
      grad_gain = 0;
   endfunction

   function void set_reg(reg_type r, logic [31:0] v);
      case (r)
         REG_MODE: mode = v[1:0];
         REG_STEP: step_size = longint'(v[30:0]);
         REG_LAPG: lap_gain = longint'(v[30:0]);
         REG_LIN:  lin_gain = longint'(signed'(v));
         REG_CUB:  cub_gain = longint'(signed'(v));
         REG_GRAD: grad_gain = longint'(signed'(v));
         default: ;
      endcase
   endfunction

   // q16.16 product, floored
   function longint qmul(longint a, longint b);
      return (a * b) >>> 16;
   endfunction

   function longint clip(longint v, inout bit flag);
      if (v > 64'sd2147483647) begin
         flag = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         flag = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function void advance(inout bit flag);
      logic signed [31:0] nd[256], nv[256];
      longint u, l, g, term, d, sq, cube;
      for (int i = 1; i < 255; i++) begin
         u = disp_now[i];
         l = longint'(disp_now[i-1]) - 2 * u + longint'(disp_now[i+1]);
         g = l * (lap_gain >>> 16) + ((l * (lap_gain & 64'sh0000_0000_0000_FFFF)) >>> 16);
         case (mode)
            MODE_MEDIUM: term = qmul(coeff[i], clip(g, flag));
            MODE_KG: begin
               sq = clip(qmul(u, u), flag);
               cube = clip(qmul(sq, u), flag);
               term = g - qmul(lin_gain, u) - qmul(cub_gain, cube);
            end
            MODE_GRAD: begin
               d = clip(longint'(disp_now[i+1]) - longint'(disp_now[i-1]), flag);
               sq = clip(qmul(d, d), flag);
               term = g + qmul(grad_gain, sq);
            end
            default: term = g;
         endcase
         nd[i] = 32'(clip(longint'(disp_old[i]) + qmul(step_size, vel_now[i]), flag));
         nv[i] = 32'(clip(longint'(vel_old[i]) + term, flag));
      end
      nd[0] = disp_now[0];
      nv[0] = vel_now[0];
      nd[255] = (mode == MODE_FREE) ? nd[254] : disp_now[255];
      nv[255] = vel_now[255];
      disp_old = disp_now;
      vel_old = vel_now;
      disp_now = nd;
      vel_now = nv;
   endfunction

   function void note_cmd(logic [1:0] cmd, logic [7:0] idx, logic signed [31:0] d,
                          logic signed [31:0] v, logic signed [31:0] m);
      cell_reply_type r;
      bit flag;
      r = '{0, 0, 0, 0};
      flag = 0;
      case (cmd)
         CMD_WRITE: begin
            disp_now[idx] = d; disp_old[idx] = d;
            vel_now[idx] = v; vel_old[idx] = v;
            coeff[idx] = m;
         end
         CMD_STEP: begin
            advance(flag);
            r.sat = flag;
            steps_done++;
            if (flag) sat_steps++;
         end
         CMD_READ: begin
            r.disp = disp_now[idx];
            r.vel = vel_now[idx];
            r.med = coeff[idx];
         end
         default: ;
      endcase
      replies_due.push_back(r);
   endfunction

   function void check(cell_reply_type got);
      cell_reply_type want;
      if (replies_due.size() == 0) begin
         $display("%0t: unexpected response d=%h v=%h m=%h s=%b", $time,
                  got.disp, got.vel, got.med, got.sat);
         errors++;
         return;
      end
      want = replies_due.pop_front();
      checked++;
      if (got.disp !== want.disp) begin
         $display("%0t: displacement exp %h got %h", $time, want.disp, got.disp);
         errors++;
      end
      if (got.vel !== want.vel) begin
         $display("%0t: velocity exp %h got %h", $time, want.vel, got.vel);
         errors++;
      end
      if (got.med !== want.med) begin
         $display("%0t: medium exp %h got %h", $time, want.med, got.med);
         errors++;
      end
      if (got.sat !== want.sat) begin
         $display("%0t: saturated exp %b got %b", $time, want.sat, got.sat);
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam longint CYCLE_LIMIT = 4000000;

   logic clock = 0;
   logic reset;
   logic csr_we;
   logic [2:0] csr_index;
   logic [31:0] csr_wdata;
   bit calm;
   longint cycles;
   int sent;

   wave_scoreboard sb;
   wss_req_if req_if ();
   wss_rsp_if rsp_if ();

   wave_string_stencil_step dut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         sb.note_cmd(req_if.cmd, req_if.cell_index, req_if.displacement_in,
                     req_if.velocity_in, req_if.medium_in);
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check('{rsp_if.displacement_out, rsp_if.velocity_out,
                    rsp_if.medium_out, rsp_if.saturated});
      rsp_if.ready <= calm || ($urandom_range(0, 99) >= 28);
   end

   task automatic send(cmd_type cmd, logic [7:0] idx, logic [31:0] d, logic [31:0] v,
                       logic [31:0] m);
      int gap;
      gap = (!calm && $urandom_range(0, 99) < 28) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_if.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_if.cmd <= cmd;
      req_if.cell_index <= idx;
      req_if.displacement_in <= d;
      req_if.velocity_in <= v;
      req_if.medium_in <= m;
      req_if.valid <= 1;
      do @(posedge clock); while (!req_if.ready);
      sent++;
   endtask

   // hold the sender until every response is back
   task automatic drain();
      req_if.valid <= 0;
      @(posedge clock);
      while (sb.replies_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_reg(reg_type r, logic [31:0] v);
      csr_we <= 1;
      csr_index <= r;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_reg(r, v);
   endtask

   function automatic logic [31:0] pick_value();
      int k;
      k = $urandom_range(0, 99);
      if (k < 60) return $urandom_range(0, 32'h000C_0000) - 32'h0006_0000;
      if (k < 85) return $urandom;
      case ($urandom_range(0, 3))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   task automatic configure(int phase);
      logic [31:0] vals[6];
      case (phase % 3)
         0: vals = '{phase % 4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h7FFF_FFFF};
         1: vals = '{phase % 4, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
         default: vals = '{phase % 4, $urandom_range(0, 32'h0002_0000),
                           $urandom_range(0, 32'h0002_0000),
                           $urandom_range(0, 32'h0002_0000) - 32'h0001_0000,
                           $urandom_range(0, 32'h0000_8000) - 32'h0000_4000,
                           $urandom_range(0, 32'h0000_8000) - 32'h0000_4000};
      endcase
      if (phase % 3 == 0 && phase % 2 == 1) vals[0] = $urandom;
      for (int r = 0; r < 6; r++) set_reg(reg_type'(r), vals[r]);
      csr_we <= 0;
   endtask

   initial begin
      int k;
      cmd_type c;
      sb = new();
      sb.clear();
      reset = 1;
      csr_we = 0;
      csr_index = 0;
      csr_wdata = 0;
      req_if.valid = 0;
      req_if.cmd = CMD_WRITE;
      req_if.cell_index = 0;
      req_if.displacement_in = 0;
      req_if.velocity_in = 0;
      req_if.medium_in = 0;
      rsp_if.ready = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // corners: boundary cells, extreme values, saturating step, unused command
      send(CMD_READ, 8'd255, 0, 0, 0);
      send(CMD_WRITE, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send(CMD_WRITE, 8'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send(CMD_WRITE, 8'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send(CMD_WRITE, 8'd254, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
      send(CMD_WRITE, 8'd255, 32'hFFFF_FFFF, 32'h0, 32'h0);
      send(CMD_NONE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(CMD_STEP, 8'd0, 0, 0, 0);
      send(CMD_READ, 8'd1, 0, 0, 0);
      send(CMD_READ, 8'd255, 0, 0, 0);
      for (int m = 1; m < 4; m++) begin
         drain();
         set_reg(REG_MODE, m);
         csr_we <= 0;
         send(CMD_STEP, 8'd7, 0, 0, 0);
         send(CMD_READ, 8'd254, 0, 0, 0);
         send(CMD_READ, 8'd2, 0, 0, 0);
      end
      send(CMD_READ, 8'd0, 0, 0, 0);

      for (int phase = 0; phase < 12; phase++) begin
         drain();
         configure(phase);
         calm = (phase == 5 || phase == 6);
         for (int n = 0; n < 145; n++) begin
            k = $urandom_range(0, 99);
            c = (k < 45) ? CMD_WRITE : (k < 87) ? CMD_READ : (k < 96) ? CMD_STEP : CMD_NONE;
            send(c, 8'($urandom_range(0, 255)), pick_value(), pick_value(), pick_value());
         end
      end
      calm = 0;
      drain();
      repeat (30) @(posedge clock);

      $display("%0d commands sent, %0d responses checked, %0d time steps (%0d saturating)",
               sent, sb.checked, sb.steps_done, sb.sat_steps);
      $display("all four modes under extreme and moderate register settings");
      if (sb.errors == 0 && sb.replies_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
